FILE: src/fvn_pkg.sv
// Shared constants, types and helper functions of the fractal value noise block.
`default_nettype none

package fvn_pkg;

  // Sizing
  localparam int unsigned MAX_OCTAVES     = 8;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned OCT_W   = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned ACC_W   = MAX_OCTAVES + 16;
  localparam int unsigned CRD_W   = 32 + COORD_FRAC_BITS;
  localparam int unsigned MUL_W   = 34;
  localparam int unsigned PROD_W  = 2 * MUL_W;

  // Hash and octave constants
  localparam logic [31:0] HASH_C1   = 32'd374761393;
  localparam logic [31:0] HASH_C2   = 32'd668265263;
  localparam logic [31:0] HASH_C3   = 32'd2246822519;
  localparam logic [31:0] HASH_C4   = 32'd1274126177;
  localparam logic [31:0] SEED_STEP = 32'd101;
  localparam logic [17:0] FADE_THREE = 18'd196608;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // Zero-extend a 32-bit word to a multiplier operand
  function automatic logic signed [MUL_W-1:0] opnd_u32(input logic [31:0] v);
    return $signed({{(MUL_W-32){1'b0}}, v});
  endfunction

  function automatic logic [31:0] hash_mix(input logic [31:0] h);
    return h ^ (h >> 13);
  endfunction

  // Final xorshift, keeping only the low half
  function automatic logic [15:0] hash_fin(input logic [31:0] h);
    return h[15:0] ^ h[31:16];
  endfunction

  // Coordinate fraction to Q0.16, truncating or zero padding
  function automatic logic [15:0] frac_q16(input logic [COORD_FRAC_BITS-1:0] fm);
    logic [COORD_FRAC_BITS+15:0] wide;
    wide = {fm, 16'h0000};
    return wide[COORD_FRAC_BITS+15:COORD_FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

FILE: src/fvn_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module fvn_mul (
  input  logic                                   clk_i,
  input  fvn_pkg::mul_req_t                      req_i,
  output logic signed [fvn_pkg::PROD_W-1:0]      prod_o
);
  import fvn_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: src/fvn_core.sv
// Octave sequencer and datapath: hashes, fade, bilinear blend and accumulation.
`default_nettype none

module fvn_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [31:0]                  x_coord_i,
  input  logic signed [31:0]                  y_coord_i,
  input  logic [31:0]                         seed_i,
  input  logic [3:0]                          octaves_i,
  output logic                                idle_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [15:0]                         res_o,
  output fvn_pkg::mul_req_t                   mul_req_o,
  input  logic signed [fvn_pkg::PROD_W-1:0]   mul_prod_i
);
  import fvn_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CX, ST_CY, ST_SD, ST_HSUM, ST_HA, ST_HB, ST_HC, ST_HD,
    ST_FX2, ST_FXT, ST_FY2, ST_FYT, ST_TOP, ST_BOT, ST_BSUM, ST_BLD, ST_ACC,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [OCT_W-1:0] oct_q, oct_d;
  logic [OCT_W-1:0] idx_q, idx_d;
  logic [OCT_W-1:0] oct_sat;

  logic [CRD_W-1:0] crd_x_q, crd_y_q;
  logic [31:0]      seed_q;
  logic [31:0]      hx_q, hy_q, base_q, top_q, bot_q;
  logic [15:0]      ca_q, cb_q, cc_q, cd_q, fade_x_q, fade_y_q;
  logic [ACC_W-1:0] acc_q;

  logic [31:0]        cx, cy;
  logic [15:0]        fx, fy;
  logic [17:0]        tx, ty;
  logic signed [16:0] diff_ab, diff_cd;
  logic signed [32:0] diff_tb;
  logic signed [33:0] top_sum, bot_sum;
  logic signed [49:0] val_sum;
  logic [15:0]        oct_val;
  logic [OCT_W-1:0]   shamt;
  logic               last_oct;
  mul_req_t           req;

  assign oct_sat = (32'(octaves_i) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                  : OCT_W'(octaves_i);

  assign cx = crd_x_q[COORD_FRAC_BITS +: 32];
  assign cy = crd_y_q[COORD_FRAC_BITS +: 32];
  assign fx = frac_q16(crd_x_q[COORD_FRAC_BITS-1:0]);
  assign fy = frac_q16(crd_y_q[COORD_FRAC_BITS-1:0]);
  assign tx = FADE_THREE - {1'b0, fx, 1'b0};
  assign ty = FADE_THREE - {1'b0, fy, 1'b0};

  assign diff_ab = $signed({1'b0, cb_q}) - $signed({1'b0, ca_q});
  assign diff_cd = $signed({1'b0, cd_q}) - $signed({1'b0, cc_q});
  assign diff_tb = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});

  assign top_sum = $signed({2'b00, ca_q, 16'h0000}) + mul_prod_i[33:0];
  assign bot_sum = $signed({2'b00, cc_q, 16'h0000}) + mul_prod_i[33:0];
  assign val_sum = $signed({2'b00, top_q, 16'h0000}) + mul_prod_i[49:0];
  assign oct_val = val_sum[47:32];

  assign shamt    = OCT_W'(MAX_OCTAVES - 1) - idx_q;
  assign last_oct = ((idx_q + OCT_W'(1)) == oct_q);

  // Operand selection for the shared multiplier
  always_comb begin
    req = '0;
    case (state_q)
      ST_CX:  begin req.a = opnd_u32(cx);     req.b = opnd_u32(HASH_C1); end
      ST_CY:  begin req.a = opnd_u32(cy);     req.b = opnd_u32(HASH_C2); end
      ST_SD:  begin req.a = opnd_u32(seed_q); req.b = opnd_u32(HASH_C3); end
      ST_HA:  begin
        req.a = opnd_u32(hash_mix(base_q));
        req.b = opnd_u32(HASH_C4);
      end
      ST_HB:  begin
        req.a = opnd_u32(hash_mix(base_q + HASH_C1));
        req.b = opnd_u32(HASH_C4);
      end
      ST_HC:  begin
        req.a = opnd_u32(hash_mix(base_q + HASH_C2));
        req.b = opnd_u32(HASH_C4);
      end
      ST_HD:  begin
        req.a = opnd_u32(hash_mix(base_q + HASH_C1 + HASH_C2));
        req.b = opnd_u32(HASH_C4);
      end
      ST_FX2: begin req.a = opnd_u32({16'h0, fx}); req.b = opnd_u32({16'h0, fx}); end
      // Square of the fraction arrives from the multiplier this cycle
      ST_FXT: begin req.a = opnd_u32(mul_prod_i[31:0]); req.b = opnd_u32({14'h0, tx}); end
      ST_FY2: begin req.a = opnd_u32({16'h0, fy}); req.b = opnd_u32({16'h0, fy}); end
      ST_FYT: begin req.a = opnd_u32(mul_prod_i[31:0]); req.b = opnd_u32({14'h0, ty}); end
      ST_TOP: begin req.a = MUL_W'(diff_ab); req.b = opnd_u32({16'h0, fade_x_q}); end
      ST_BOT: begin req.a = MUL_W'(diff_cd); req.b = opnd_u32({16'h0, fade_x_q}); end
      ST_BLD: begin req.a = MUL_W'(diff_tb); req.b = opnd_u32({16'h0, fade_y_q}); end
      default: req = '0;
    endcase
  end

  assign mul_req_o = req;

  // Sequencer
  always_comb begin
    state_d = state_q;
    oct_d   = oct_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          oct_d   = oct_sat;
          idx_d   = '0;
          state_d = (oct_sat == '0) ? ST_DONE : ST_CX;
        end
      end
      ST_CX:   state_d = ST_CY;
      ST_CY:   state_d = ST_SD;
      ST_SD:   state_d = ST_HSUM;
      ST_HSUM: state_d = ST_HA;
      ST_HA:   state_d = ST_HB;
      ST_HB:   state_d = ST_HC;
      ST_HC:   state_d = ST_HD;
      ST_HD:   state_d = ST_FX2;
      ST_FX2:  state_d = ST_FXT;
      ST_FXT:  state_d = ST_FY2;
      ST_FY2:  state_d = ST_FYT;
      ST_FYT:  state_d = ST_TOP;
      ST_TOP:  state_d = ST_BOT;
      ST_BOT:  state_d = ST_BSUM;
      ST_BSUM: state_d = ST_BLD;
      ST_BLD:  state_d = ST_ACC;
      ST_ACC: begin
        if (last_oct) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + OCT_W'(1);
          state_d = ST_CX;
        end
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oct_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      oct_q   <= oct_d;
      idx_q   <= idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          crd_x_q <= {{COORD_FRAC_BITS{x_coord_i[31]}}, x_coord_i};
          crd_y_q <= {{COORD_FRAC_BITS{y_coord_i[31]}}, y_coord_i};
          seed_q  <= seed_i;
          acc_q   <= '0;
        end
      end
      ST_CY:   hx_q     <= mul_prod_i[31:0];
      ST_SD:   hy_q     <= mul_prod_i[31:0];
      ST_HSUM: base_q   <= hx_q + hy_q + mul_prod_i[31:0];
      ST_HB:   ca_q     <= hash_fin(mul_prod_i[31:0]);
      ST_HC:   cb_q     <= hash_fin(mul_prod_i[31:0]);
      ST_HD:   cc_q     <= hash_fin(mul_prod_i[31:0]);
      ST_FX2:  cd_q     <= hash_fin(mul_prod_i[31:0]);
      ST_FY2:  fade_x_q <= mul_prod_i[47:32];
      ST_TOP:  fade_y_q <= mul_prod_i[47:32];
      ST_BOT:  top_q    <= top_sum[31:0];
      ST_BSUM: bot_q    <= bot_sum[31:0];
      ST_ACC: begin
        acc_q   <= acc_q + (ACC_W'(oct_val) << shamt);
        crd_x_q <= {crd_x_q[CRD_W-2:0], 1'b0};
        crd_y_q <= {crd_y_q[CRD_W-2:0], 1'b0};
        seed_q  <= seed_q + SEED_STEP;
      end
      default: ;
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = acc_q[ACC_W-1:MAX_OCTAVES];

endmodule

`default_nettype wire

FILE: src/fractal_value_noise_2d.sv
// Top level of the fractal value noise block: handshakes, output register, core and multiplier.
`default_nettype none

// Fractal value noise over a 2-D plane. Each input word carries a signed Q16.16
// point, a 32-bit seed and an octave count (counts above eight are treated as
// eight); each produces one output word, the noise sum as an unsigned Q0.16
// fraction. Every arithmetic step - the four lattice hashes, the two smoothstep
// fades and the three interpolations - goes through one shared 34x34 signed
// multiplier, so the steps of an octave run one after another through the
// sequencer states. A word holds in_ready_o low until its result has passed
// into the output register, so words are taken one at a time. The result is
// held in an output register, so the next input word is taken while a finished
// result still waits for out_ready_i. Reset is asynchronous and active low; no
// clearing pass is needed.
module fractal_value_noise_2d (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic [31:0]        seed_i,
  input  logic [3:0]         octaves_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        noise_value_o
);
  import fvn_pkg::*;

  logic                     core_idle;
  logic                     res_valid, res_ready;
  logic [15:0]              res;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] mul_prod;

  logic        out_valid_q, out_valid_d;
  logic [15:0] noise_q;
  logic        load;

  // Take a new word only while the sequencer sits idle
  assign in_ready_o = core_idle;

  fvn_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i & core_idle),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .seed_i      (seed_i),
    .octaves_i   (octaves_i),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mul_req_o   (mul_req),
    .mul_prod_i  (mul_prod)
  );

  fvn_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  // Output register: load when empty or being drained this cycle
  assign res_ready   = !out_valid_q || out_ready_i;
  assign load        = res_valid && res_ready;
  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      noise_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for fractal_value_noise_2d: stimulus, noise predictor and scoreboard.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Octave counts above this are clipped by the block.
  localparam int unsigned OCT_LIMIT = 8;
  // Fraction bits of the Q16.16 coordinates.
  localparam int unsigned FRAC = 16;
  // Random words after the directed part, split evenly over three idling phases.
  localparam int unsigned RANDOM_WORDS = 1680;
  // Let at least the worst core occupancy of one word pass after the last result.
  localparam int unsigned DRAIN_CYCLES = 160;

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts each accepted word and checks results in order.
  // ---------------------------------------------------------------------------
  class noise_scoreboard;
    typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] seed;
      logic [3:0]  oct;
      logic [15:0] noise;
    } pending_t;

    pending_t    pending_noise[$];
    int unsigned mismatches     = 0;
    int unsigned words_noted    = 0;
    int unsigned results_seen   = 0;
    int unsigned zero_oct_words = 0;
    int unsigned clipped_words  = 0;

    // Multiply-xorshift hash of one lattice corner.
    static function logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cy,
                                           logic [31:0] sd);
      logic [31:0] h;
      h = cx * 32'd374761393 + cy * 32'd668265263 + sd * 32'd2246822519;
      h = (h ^ (h >> 13)) * 32'd1274126177;
      return h ^ (h >> 16);
    endfunction

    // Low half of the corner hash as a Q0.16 value.
    static function logic [63:0] corner_q16(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] sd);
      return 64'(cell_hash(cx, cy, sd) & 32'h0000_FFFF);
    endfunction

    // Smoothstep f*f*(3-2f), Q0.16 in and out, truncated.
    static function logic [63:0] smooth_fade(logic [63:0] f);
      logic [63:0] f2;
      logic [63:0] t;
      f2 = f * f;
      t  = 64'd196608 - 2 * f;
      return (f2 * t) >> 32;
    endfunction

    // One octave: lattice cell, faded fraction and bilinear blend, Q0.16.
    static function logic [63:0] octave_value(logic [63:0] xs, logic [63:0] ys,
                                              logic [31:0] sd);
      logic [31:0] cx;
      logic [31:0] cy;
      logic [63:0] fx;
      logic [63:0] fy;
      logic [63:0] top;
      logic [63:0] bot;
      logic [63:0] v;
      cx  = xs[FRAC+31:FRAC];
      cy  = ys[FRAC+31:FRAC];
      fx  = smooth_fade(64'(xs[FRAC-1:0]));
      fy  = smooth_fade(64'(ys[FRAC-1:0]));
      top = corner_q16(cx, cy, sd) * (64'd65536 - fx)
          + corner_q16(cx + 32'd1, cy, sd) * fx;
      bot = corner_q16(cx, cy + 32'd1, sd) * (64'd65536 - fx)
          + corner_q16(cx + 32'd1, cy + 32'd1, sd) * fx;
      v   = top * (64'd65536 - fy) + bot * fy;
      return v >> 32;
    endfunction

    // Fractal sum over the octaves, weighted 2^-(i+1) and truncated once.
    static function logic [15:0] fbm_noise(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] seed, logic [3:0] oct);
      logic [63:0] xe;
      logic [63:0] ye;
      logic [63:0] acc;
      int unsigned n;
      xe  = {{32{x[31]}}, x};
      ye  = {{32{y[31]}}, y};
      acc = '0;
      n   = (oct > OCT_LIMIT) ? OCT_LIMIT : oct;
      for (int unsigned i = 0; i < n; i++) begin
        acc += octave_value(xe << i, ye << i, seed + 32'(101 * i)) << (OCT_LIMIT - 1 - i);
      end
      return acc[OCT_LIMIT+15:OCT_LIMIT];
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_input(logic [31:0] x, logic [31:0] y, logic [31:0] seed,
                             logic [3:0] oct);
      pending_t p;
      p.x     = x;
      p.y     = y;
      p.seed  = seed;
      p.oct   = oct;
      p.noise = fbm_noise(x, y, seed, oct);
      pending_noise.push_back(p);
      words_noted++;
      if (oct == 0) zero_oct_words++;
      if (oct > OCT_LIMIT) clipped_words++;
    endfunction

    task check_result(logic [15:0] got);
      pending_t p;
      results_seen++;
      if (pending_noise.size() == 0) begin
        report_mismatch($sformatf("noise word %h with no input outstanding", got));
      end else begin
        p = pending_noise.pop_front();
        if (got !== p.noise) begin
          report_mismatch($sformatf("x=%h y=%h seed=%h oct=%0d: noise %h, predicted %h",
                                    p.x, p.y, p.seed, p.oct, got, p.noise));
        end
      end
    endtask

    function int unsigned outstanding();
      return pending_noise.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block signals. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [31:0] x_coord   = '0;
  logic [31:0] y_coord   = '0;
  logic [31:0] seed      = '0;
  logic [3:0]  octaves   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] noise_value;

  // Idle percentages of sender and receiver, changed between phases.
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 52;

  noise_scoreboard sb;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fractal_value_noise_2d uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .x_coord_i     (x_coord),
    .y_coord_i     (y_coord),
    .seed_i        (seed),
    .octaves_i     (octaves),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .noise_value_o (noise_value)
  );

  // ---------------------------------------------------------------------------
  // Receiver: decide ready at the falling edge, take results at the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(noise_value);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: offer one word, holding it steady until the block takes it.
  // Valid is only lowered during an idle gap, so a word that follows
  // directly keeps valid high without a drop in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] sd,
                           logic [3:0] oct);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_coord  <= x;
    y_coord  <= y;
    seed     <= sd;
    octaves  <= oct;
    // Hold until a rising edge sees valid and ready together.
    do @(posedge clk); while (!in_ready);
    sb.note_input(x, y, sd, oct);
  endtask

  // Random word: mostly full-range coordinates, some close to the origin so that
  // neighbouring cells and sign changes recur; octave counts favour the legal range.
  task automatic send_random_word();
    logic [31:0] x;
    logic [31:0] y;
    logic [3:0]  oct;
    x = $urandom;
    y = $urandom;
    if ($urandom_range(0, 3) == 0) x = $urandom_range(0, 32'h3FFFF) - 32'h20000;
    if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 32'h3FFFF) - 32'h20000;
    if ($urandom_range(0, 3) == 0) oct = 4'($urandom_range(0, 15));
    else                           oct = 4'($urandom_range(1, OCT_LIMIT));
    send_word(x, y, $urandom, oct);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    sb = new;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: zero octaves, every count up to the limit and some past it,
    // extreme and negative coordinates, fraction extremes and seed wrap-around.
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_word(32'h1234_5678, 32'h9ABC_DEF0, 32'hDEAD_BEEF, 4'd0);
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd1);
    send_word(32'h0001_8000, 32'h0002_4000, 32'h0000_0001, 4'd2);
    send_word(32'h0003_0001, 32'h0005_FFFF, 32'h0000_0007, 4'd3);
    send_word(32'h0000_FFFF, 32'h0000_FFFF, 32'h0BAD_F00D, 4'd4);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1357_9BDF, 4'd5);
    send_word(32'hFFFE_8000, 32'h0001_8000, 32'h2468_ACE0, 4'd6);
    send_word(32'h0001_8000, 32'hFFFE_8000, 32'hFFFF_FFFF, 4'd7);
    send_word(32'h0010_0010, 32'hFFF0_FFF0, 32'h8000_0000, 4'd8);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd8);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 4'd8);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0, 4'd8);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FD00, 4'd8);
    send_word(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 4'd8);
    send_word(32'h0005_5555, 32'hFFFA_AAAB, 32'h5555_5555, 4'd9);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 4'd10);
    send_word(32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0000, 4'd12);
    send_word(32'h4000_0000, 32'hC000_0000, 32'h0F0F_0F0F, 4'd15);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 32'hF0F0_F0F0, 4'd15);

    // Random words in three idling phases: sender lighter, receiver lighter, none.
    repeat (RANDOM_WORDS / 3) send_random_word();
    send_idle_pct = 52;
    recv_idle_pct = 34;
    repeat (RANDOM_WORDS / 3) send_random_word();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_WORDS / 3) send_random_word();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then watch for stray results.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input words (%0d with zero octaves, %0d above the octave limit),",
             sb.words_noted, sb.zero_oct_words, sb.clipped_words);
    $display("checked %0d noise words under three idling mixes; %0d mismatches.",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("fractal_value_noise_2d regression: pass");
    end else begin
      $display("fractal_value_noise_2d regression: fail");
    end
    $finish;
  end

  // Watchdog: a few times the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout with %0d noise words still outstanding.", sb.outstanding());
    $display("fractal_value_noise_2d regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
